@@ design/rgb_hsl_hsv_converter_assert.svh @@
// ----------------------------------------------------------------------------
// rgb_hsl_hsv_converter_assert.svh
// assertion macros used by the converter
// ----------------------------------------------------------------------------
`ifndef RGB_HSL_HSV_CONVERTER_ASSERT_SVH
`define RGB_HSL_HSV_CONVERTER_ASSERT_SVH

// consequent checked in the same cycle
`define RHHC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the following cycle
`define RHHC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/rhhc_pkg.sv @@
// ----------------------------------------------------------------------------
// rhhc_pkg
// types, constants and helpers of the rgb / hsl / hsv converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rhhc_pkg;

    // color model codes
    localparam logic [1:0] MODEL_RGB = 2'd0;
    localparam logic [1:0] MODEL_HSL = 2'd1;
    localparam logic [1:0] MODEL_HSV = 2'd2;
    localparam logic [1:0] MODEL_BAD = 2'd3;

    localparam logic [10:0] HUE_FULL = 11'd1536;

    // divider geometry: quotient bits, remainder and divisor widths
    localparam int DIV_STEPS = 9;
    localparam int REM_W     = 17;
    localparam int DEN_W     = 9;

    typedef struct packed {
        logic [1:0]  source_model;
        logic [1:0]  target_model;
        logic [10:0] first_in;
        logic [7:0]  second_in;
        logic [7:0]  third_in;
        logic [7:0]  alpha_in;
    } pix_in_t;

    typedef struct packed {
        logic [1:0]  result_model;
        logic [10:0] first_out;
        logic [7:0]  second_out;
        logic [7:0]  third_out;
        logic [7:0]  alpha_out;
    } pix_out_t;

    // information riding alongside the divider
    typedef struct packed {
        logic [1:0]  dst;
        logic        direct;
        logic [10:0] f0;
        logic [7:0]  f1;
        logic [7:0]  f2;
        logic [7:0]  alpha;
        logic        hue_zero;
        logic        hue_neg;
        logic [10:0] hue_base;
        logic        sat_zero;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0] num_hue;
        logic [DEN_W-1:0] den_hue;
        logic [REM_W-1:0] num_sat;
        logic [DEN_W-1:0] den_sat;
        side_t            side;
    } div_in_t;

    typedef struct packed {
        logic [DIV_STEPS-1:0] q_hue;
        logic [DIV_STEPS-1:0] q_sat;
        side_t                side;
    } div_out_t;

    // round(x / 65280): pre-round to /256, then /255 by multiply with 257
    function automatic logic [7:0] round_div65280(input logic [23:0] x);
        logic [24:0] xs;
        logic [16:0] y;
        logic [25:0] m;
        xs = 25'(x) + 25'd32640;
        y  = xs[24:8];
        m  = 26'(y) * 26'd257 + 26'd257;
        if (m[25:24] != 2'b00)
            return 8'hFF;
        else
            return m[23:16];
    endfunction

endpackage

@@ design/rgb_hsl_hsv_converter.sv @@
// Converts one color word per clock, unless the output stalls, between RGB, HSL and HSV, alpha copied.
// The pipeline is fifteen register stages deep: input capture, three stages
// that bring HSL or HSV to RGB (products, channel sums, rounding), one stage
// that prepares hue and saturation quotients, nine stages of a restoring
// divider that resolve one quotient bit each, and the output register. A
// new word is taken every cycle unless the pipeline stalls. Ready is held
// low only when every stage holds a word and the output is not being taken.
// ----------------------------------------------------------------------------
// rgb_hsl_hsv_converter
// streaming color model converter, unless stalled one word per clock
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_hsl_hsv_converter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  rhhc_pkg::pix_in_t  in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output rhhc_pkg::pix_out_t out_data
);
    import rhhc_pkg::*;

    localparam int NSTG  = DIV_STEPS + 6;
    localparam int DIV0  = 5;

    typedef struct packed {
        logic [1:0]  src;
        logic [1:0]  dst;
        logic [10:0] ch0;
        logic [7:0]  ch1;
        logic [7:0]  ch2;
        logic [7:0]  alpha;
    } base_t;

    typedef struct packed {
        base_t       bs;
        logic [15:0] q;
        logic [15:0] p;
        logic [10:0] tr;
        logic [10:0] tg;
        logic [10:0] tb;
        logic [15:0] vs;
        logic [15:0] fs;
    } st1_t;

    typedef struct packed {
        base_t       bs;
        logic [23:0] hx_r;
        logic [23:0] hx_g;
        logic [23:0] hx_b;
        logic [23:0] xq;
        logic [23:0] xt;
        logic [23:0] xp;
    } st2_t;

    typedef struct packed {
        base_t      bs;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } st3_t;

    // hsl channel weight for a hue position
    function automatic logic [8:0] hue_weight(input logic [10:0] t);
        logic [10:0] tmp;
        tmp = 11'd1024 - t;
        if (t < 11'd256)
            return t[8:0];
        else if (t < 11'd768)
            return 9'd256;
        else if (t < 11'd1024)
            return tmp[8:0];
        else
            return 9'd0;
    endfunction

    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    base_t    st0_reg, st0_next;
    st1_t     st1_reg, st1_next;
    st2_t     st2_reg, st2_next;
    st3_t     st3_reg, st3_next;
    div_in_t  st4_reg, st4_next;
    div_out_t div_out;
    pix_out_t out_reg, out_next;

    // stall chain: a stage moves when it is empty or the next one moves
    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NSTG; i++)
            begin
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    // stage 0: normalize model codes, wrap hue, clamp red
    always_comb
    begin
        st0_next.src   = (in_data.source_model == MODEL_BAD) ? MODEL_RGB
                                                             : in_data.source_model;
        st0_next.dst   = (in_data.target_model == MODEL_BAD) ? MODEL_RGB
                                                             : in_data.target_model;
        st0_next.ch0   = in_data.first_in;
        if (st0_next.src == MODEL_RGB)
        begin
            if (in_data.first_in > 11'd255)
                st0_next.ch0 = 11'd255;
        end
        else if (in_data.first_in >= HUE_FULL)
            st0_next.ch0 = in_data.first_in - HUE_FULL;
        st0_next.ch1   = in_data.second_in;
        st0_next.ch2   = in_data.third_in;
        st0_next.alpha = in_data.alpha_in;
    end

    // stage 1: hsl q and p, hsv products, hue positions
    logic [15:0] m_ls;
    logic [16:0] q17;
    logic [16:0] p17;
    logic [11:0] h_r;
    logic [11:0] h_b;
    always_comb
    begin
        m_ls = 16'(st0_reg.ch2) * 16'(st0_reg.ch1);
        if (!st0_reg.ch2[7])
            q17 = 17'(st0_reg.ch2) * 17'd255 + 17'(m_ls);
        else
            q17 = (17'(st0_reg.ch2) + 17'(st0_reg.ch1)) * 17'd255 - 17'(m_ls);
        p17 = 17'(st0_reg.ch2) * 17'd510 - q17;
        h_r = 12'(st0_reg.ch0) + 12'd512;
        h_b = 12'(st0_reg.ch0) + 12'd1024;
        st1_next.bs = st0_reg;
        st1_next.q  = q17[15:0];
        st1_next.p  = p17[15:0];
        st1_next.tg = st0_reg.ch0;
        st1_next.tr = (h_r >= 12'(HUE_FULL)) ? 11'(h_r - 12'(HUE_FULL)) : h_r[10:0];
        st1_next.tb = (h_b >= 12'(HUE_FULL)) ? 11'(h_b - 12'(HUE_FULL)) : h_b[10:0];
        st1_next.vs = 16'(st0_reg.ch2) * 16'(8'd255 - st0_reg.ch1);
        st1_next.fs = 16'(st0_reg.ch0[7:0]) * 16'(st0_reg.ch1);
    end

    // stage 2: channel sums before rounding
    logic [15:0] dqp;
    logic [15:0] s_tail;
    always_comb
    begin
        dqp    = st1_reg.q - st1_reg.p;
        s_tail = {st1_reg.bs.ch1, 8'h00} - st1_reg.fs;
        st2_next.bs   = st1_reg.bs;
        st2_next.hx_r = {st1_reg.p, 8'h00} + 24'(dqp) * 24'(hue_weight(st1_reg.tr));
        st2_next.hx_g = {st1_reg.p, 8'h00} + 24'(dqp) * 24'(hue_weight(st1_reg.tg));
        st2_next.hx_b = {st1_reg.p, 8'h00} + 24'(dqp) * 24'(hue_weight(st1_reg.tb));
        st2_next.xq   = 24'(st1_reg.bs.ch2) * 24'(16'd65280 - st1_reg.fs);
        st2_next.xt   = 24'(st1_reg.bs.ch2) * 24'(16'd65280 - s_tail);
        st2_next.xp   = {st1_reg.vs, 8'h00};
    end

    // stage 3: round to 8 bits and pick rgb
    logic [7:0] pv, qv, tv, vv;
    always_comb
    begin
        pv = round_div65280(st2_reg.xp);
        qv = round_div65280(st2_reg.xq);
        tv = round_div65280(st2_reg.xt);
        vv = st2_reg.bs.ch2;
        st3_next.bs = st2_reg.bs;
        st3_next.r  = st2_reg.bs.ch0[7:0];
        st3_next.g  = st2_reg.bs.ch1;
        st3_next.b  = st2_reg.bs.ch2;
        if (st2_reg.bs.src == MODEL_HSL)
        begin
            if (st2_reg.bs.ch1 != 8'd0)
            begin
                st3_next.r = round_div65280(st2_reg.hx_r);
                st3_next.g = round_div65280(st2_reg.hx_g);
                st3_next.b = round_div65280(st2_reg.hx_b);
            end
            else
            begin
                // gray: every channel equals lightness
                st3_next.r = st2_reg.bs.ch2;
                st3_next.g = st2_reg.bs.ch2;
                st3_next.b = st2_reg.bs.ch2;
            end
        end
        else if (st2_reg.bs.src == MODEL_HSV)
        begin
            case (st2_reg.bs.ch0[10:8])
                3'd0:    begin st3_next.r = vv; st3_next.g = tv; st3_next.b = pv; end
                3'd1:    begin st3_next.r = qv; st3_next.g = vv; st3_next.b = pv; end
                3'd2:    begin st3_next.r = pv; st3_next.g = vv; st3_next.b = tv; end
                3'd3:    begin st3_next.r = pv; st3_next.g = qv; st3_next.b = vv; end
                3'd4:    begin st3_next.r = tv; st3_next.g = pv; st3_next.b = vv; end
                default: begin st3_next.r = vv; st3_next.g = pv; st3_next.b = qv; end
            endcase
        end
    end

    // stage 4: extremes, hue sector, divider operands
    logic [7:0] mx, mn, dd, ha, hc, diff, sden;
    logic [8:0] sum;
    logic [8:0] light9;
    logic       pass;
    always_comb
    begin
        mx = st3_reg.r;
        if (st3_reg.g > mx) mx = st3_reg.g;
        if (st3_reg.b > mx) mx = st3_reg.b;
        mn = st3_reg.r;
        if (st3_reg.g < mn) mn = st3_reg.g;
        if (st3_reg.b < mn) mn = st3_reg.b;
        dd     = mx - mn;
        sum    = 9'(mx) + 9'(mn);
        light9 = (sum + 9'd1) >> 1;
        pass   = (st3_reg.bs.src == st3_reg.bs.dst);

        st4_next.side.hue_base = 11'd0;
        ha = st3_reg.g;
        hc = st3_reg.b;
        if (mx == st3_reg.r)
        begin
            ha = st3_reg.g;
            hc = st3_reg.b;
        end
        else if (mx == st3_reg.g)
        begin
            ha = st3_reg.b;
            hc = st3_reg.r;
            st4_next.side.hue_base = 11'd512;
        end
        else
        begin
            ha = st3_reg.r;
            hc = st3_reg.g;
            st4_next.side.hue_base = 11'd1024;
        end
        st4_next.side.hue_neg = (ha < hc);
        diff = (ha < hc) ? hc - ha : ha - hc;

        if (st3_reg.bs.dst == MODEL_HSV)
            sden = mx;
        else if (sum > 9'd255)
            sden = 8'(9'd510 - sum);
        else
            sden = sum[7:0];

        // rounded 256 * diff / dd as (512 * diff + dd) / (2 * dd)
        st4_next.num_hue = {diff, 9'h000} + REM_W'(dd);
        st4_next.den_hue = (dd == 8'd0) ? DEN_W'(2) : {dd, 1'b0};
        st4_next.num_sat = 17'(16'(dd) * 16'd255) * 17'd2 + REM_W'(sden);
        st4_next.den_sat = (dd == 8'd0) ? DEN_W'(2) : {sden, 1'b0};

        st4_next.side.dst      = st3_reg.bs.dst;
        st4_next.side.direct   = pass || (st3_reg.bs.dst == MODEL_RGB);
        st4_next.side.alpha    = st3_reg.bs.alpha;
        st4_next.side.hue_zero = (dd == 8'd0);
        st4_next.side.sat_zero = (dd == 8'd0);
        if (pass)
        begin
            st4_next.side.f0 = st3_reg.bs.ch0;
            st4_next.side.f1 = st3_reg.bs.ch1;
            st4_next.side.f2 = st3_reg.bs.ch2;
        end
        else
        begin
            st4_next.side.f0 = 11'(st3_reg.r);
            st4_next.side.f1 = st3_reg.g;
            if (st3_reg.bs.dst == MODEL_RGB)
                st4_next.side.f2 = st3_reg.b;
            else if (st3_reg.bs.dst == MODEL_HSL)
                st4_next.side.f2 = light9[7:0];
            else
                st4_next.side.f2 = mx;
        end
    end

    // front stage registers
    always_ff @(posedge clk)
    begin
        if (en[0]) st0_reg <= st0_next;
        if (en[1]) st1_reg <= st1_next;
        if (en[2]) st2_reg <= st2_next;
        if (en[3]) st3_reg <= st3_next;
        if (en[4]) st4_reg <= st4_next;
    end

    rhhc_div u_div (
        .clk  (clk),
        .en   (en[DIV0 +: DIV_STEPS]),
        .din  (st4_reg),
        .dout (div_out)
    );

    // output stage: hue from sector base and offset, final selection
    logic [11:0] hue12;
    logic [11:0] hue_w;
    always_comb
    begin
        if (!div_out.side.hue_neg)
            hue12 = 12'(div_out.side.hue_base) + 12'(div_out.q_hue);
        else if (div_out.side.hue_base == 11'd0)
            hue12 = 12'(HUE_FULL) - 12'(div_out.q_hue);
        else
            hue12 = 12'(div_out.side.hue_base) - 12'(div_out.q_hue);
        hue_w = (hue12 >= 12'(HUE_FULL)) ? hue12 - 12'(HUE_FULL) : hue12;

        out_next.result_model = div_out.side.dst;
        out_next.alpha_out    = div_out.side.alpha;
        out_next.third_out    = div_out.side.f2;
        if (div_out.side.direct)
        begin
            out_next.first_out  = div_out.side.f0;
            out_next.second_out = div_out.side.f1;
        end
        else
        begin
            out_next.first_out  = div_out.side.hue_zero ? 11'd0 : hue_w[10:0];
            out_next.second_out = div_out.side.sat_zero ? 8'd0 : div_out.q_sat[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NSTG-1])
            out_reg <= out_next;
    end

    // checks
    `include "rgb_hsl_hsv_converter_assert.svh"

    `RHHC_ASSERT_SAME(a_ready_full, !in_ready, (&v_reg) && !out_ready, "stall with empty stage")
    `RHHC_ASSERT_SAME(a_first_range, out_valid, (out_data.result_model == MODEL_RGB) ? (out_data.first_out <= 11'd255) : (out_data.first_out < HUE_FULL), "first field out of range")
    `RHHC_ASSERT_NEXT(a_take_word, in_valid && in_ready, v_reg[0], "accepted word lost")

endmodule

@@ design/rhhc_div.sv @@
// ----------------------------------------------------------------------------
// rhhc_div
// pipelined restoring divider, two quotients, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhhc_div (
    input  logic                          clk,
    input  logic [rhhc_pkg::DIV_STEPS-1:0] en,
    input  rhhc_pkg::div_in_t             din,
    output rhhc_pkg::div_out_t            dout
);
    import rhhc_pkg::*;

    typedef struct packed {
        logic [REM_W-1:0]     rem_hue;
        logic [DEN_W-1:0]     den_hue;
        logic [DIV_STEPS-1:0] q_hue;
        logic [REM_W-1:0]     rem_sat;
        logic [DEN_W-1:0]     den_sat;
        logic [DIV_STEPS-1:0] q_sat;
        side_t                side;
    } dstage_t;

    dstage_t stage_reg [DIV_STEPS];

    // stage zero takes the numerators as the running remainders
    dstage_t first_stage;
    always_comb
    begin
        first_stage.rem_hue = din.num_hue;
        first_stage.den_hue = din.den_hue;
        first_stage.q_hue   = '0;
        first_stage.rem_sat = din.num_sat;
        first_stage.den_sat = din.den_sat;
        first_stage.q_sat   = '0;
        first_stage.side    = din.side;
    end

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_step
        localparam int BIT = DIV_STEPS - 1 - k;
        dstage_t          prev;
        dstage_t          stage_next;
        logic [REM_W-1:0] trial_hue;
        logic [REM_W-1:0] trial_sat;

        if (k == 0)
        begin : g_head
            assign prev = first_stage;
        end
        else
        begin : g_body
            assign prev = stage_reg[k-1];
        end

        // compare and subtract the shifted divisor
        always_comb
        begin
            trial_hue  = REM_W'(prev.den_hue) << BIT;
            trial_sat  = REM_W'(prev.den_sat) << BIT;
            stage_next = prev;
            if (prev.rem_hue >= trial_hue)
            begin
                stage_next.rem_hue     = prev.rem_hue - trial_hue;
                stage_next.q_hue[BIT]  = 1'b1;
            end
            if (prev.rem_sat >= trial_sat)
            begin
                stage_next.rem_sat     = prev.rem_sat - trial_sat;
                stage_next.q_sat[BIT]  = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[k])
                stage_reg[k] <= stage_next;
        end
    end

    assign dout.q_hue = stage_reg[DIV_STEPS-1].q_hue;
    assign dout.q_sat = stage_reg[DIV_STEPS-1].q_sat;
    assign dout.side  = stage_reg[DIV_STEPS-1].side;

endmodule

@@ dv/color_convert_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_convert_checker
// watches both channels of the converter, computes the expected color for
// every accepted input word and compares it with each accepted output word
// ----------------------------------------------------------------------------

module color_convert_checker
    import rhhc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  pix_in_t  in_data,
    input  logic     out_valid,
    input  logic     out_ready,
    input  pix_out_t out_data,
    output int       fail_count,
    output int       pending,
    output int       words_checked
);

    pix_out_t expected_colors[$];

    // rounded quotient, ties upward
    function automatic int unsigned rdiv(input int unsigned n, input int unsigned d);
        return (2 * n + d) / (2 * d);
    endfunction

    function automatic int unsigned hue_from_rgb(input int unsigned r, g, b, mx, mn);
        int unsigned d, a, c, base, off, h;
        d = mx - mn;
        if (d == 0)
            return 0;
        if (mx == r)
        begin
            a = g; c = b; base = 0;
        end
        else if (mx == g)
        begin
            a = b; c = r; base = 512;
        end
        else
        begin
            a = r; c = g; base = 1024;
        end
        if (a >= c)
            h = base + rdiv(256 * (a - c), d);
        else
        begin
            off = rdiv(256 * (c - a), d);
            h = (base == 0) ? 1536 - off : base - off;
        end
        if (h >= 1536)
            h -= 1536;
        return h;
    endfunction

    function automatic int unsigned hsl_channel(input int unsigned p, q, t);
        int unsigned x;
        if (t < 256)
            x = p * 256 + (q - p) * t;
        else if (t < 768)
            x = q * 256;
        else if (t < 1024)
            x = p * 256 + (q - p) * (1024 - t);
        else
            x = p * 256;
        return rdiv(x, 65280);
    endfunction

    function automatic pix_out_t convert_color(input pix_in_t w);
        logic [1:0]  src, dst;
        int unsigned c0, c1, c2, r, g, b, mx, mn, sum, den, p, q;
        int unsigned sec, f, pv, qv, tv;
        pix_out_t res;
        src = (w.source_model == MODEL_BAD) ? MODEL_RGB : w.source_model;
        dst = (w.target_model == MODEL_BAD) ? MODEL_RGB : w.target_model;
        c0 = 32'(w.first_in);
        if (src == MODEL_RGB)
        begin
            if (c0 > 255)
                c0 = 255;
        end
        else if (c0 >= 1536)
            c0 -= 1536;
        c1 = 32'(w.second_in);
        c2 = 32'(w.third_in);
        res.result_model = dst;
        res.alpha_out    = w.alpha_in;
        if (src == dst)
        begin
            res.first_out = 11'(c0); res.second_out = 8'(c1); res.third_out = 8'(c2);
            return res;
        end
        // source to rgb
        r = c0; g = c1; b = c2;
        if (src == MODEL_HSL)
        begin
            if (c1 == 0)
            begin
                r = c2; g = c2; b = c2;
            end
            else
            begin
                q = (c2 < 128) ? c2 * (255 + c1) : 255 * (c2 + c1) - c2 * c1;
                p = 510 * c2 - q;
                r = hsl_channel(p, q, (c0 + 512) % 1536);
                g = hsl_channel(p, q, c0);
                b = hsl_channel(p, q, (c0 + 1024) % 1536);
            end
        end
        else if (src == MODEL_HSV)
        begin
            sec = c0 >> 8;
            f   = c0 & 255;
            pv  = rdiv(c2 * (255 - c1) * 256, 65280);
            qv  = rdiv(c2 * (65280 - f * c1), 65280);
            tv  = rdiv(c2 * (65280 - (256 - f) * c1), 65280);
            case (sec)
                0: begin r = c2; g = tv; b = pv; end
                1: begin r = qv; g = c2; b = pv; end
                2: begin r = pv; g = c2; b = tv; end
                3: begin r = pv; g = qv; b = c2; end
                4: begin r = tv; g = pv; b = c2; end
                default: begin r = c2; g = pv; b = qv; end
            endcase
        end
        // rgb to target
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        if (dst == MODEL_RGB)
        begin
            res.first_out = 11'(r); res.second_out = 8'(g); res.third_out = 8'(b);
        end
        else if (dst == MODEL_HSL)
        begin
            sum = mx + mn;
            res.first_out = 11'(hue_from_rgb(r, g, b, mx, mn));
            res.third_out = 8'((sum + 1) >> 1);
            if (mx == mn)
                res.second_out = '0;
            else
            begin
                den = (sum > 255) ? 510 - sum : sum;
                res.second_out = 8'(rdiv(255 * (mx - mn), den));
            end
        end
        else
        begin
            res.first_out  = 11'(hue_from_rgb(r, g, b, mx, mn));
            res.second_out = (mx == 0) ? 8'd0 : 8'(rdiv(255 * (mx - mn), mx));
            res.third_out  = 8'(mx);
        end
        return res;
    endfunction

    // predict on input, compare on output
    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t exp_w;
        if (!rst_n)
        begin
            fail_count    <= 0;
            words_checked <= 0;
            pending       <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_colors.push_back(convert_color(in_data));
            if (out_valid && out_ready)
            begin
                words_checked <= words_checked + 1;
                if (expected_colors.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected output word %h", out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_w = expected_colors.pop_front();
                    if (exp_w !== out_data)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: exp model %0d %0d %0d %0d a %0d, %s",
                                exp_w.result_model, exp_w.first_out, exp_w.second_out,
                                exp_w.third_out, exp_w.alpha_out,
                                $sformatf("got model %0d %0d %0d %0d a %0d",
                                    out_data.result_model, out_data.first_out,
                                    out_data.second_out, out_data.third_out,
                                    out_data.alpha_out));
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_colors.size();
        end
    end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives directed and random colors through the converter with random gaps
// on both sides; the checker predicts and compares every word
// ----------------------------------------------------------------------------

module tb_top;
    import rhhc_pkg::*;

    localparam int WATCHDOG = 20000;

    logic     clk;
    logic     rst_n;
    logic     in_valid;
    logic     in_ready;
    pix_in_t  in_data;
    logic     out_valid;
    logic     out_ready;
    pix_out_t out_data;
    int       fail_count;
    int       pending;
    int       words_checked;
    int       idle_cycles;
    int       words_sent;

    rgb_hsl_hsv_converter dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    color_convert_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .fail_count(fail_count), .pending(pending), .words_checked(words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one, sometimes none
    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 40)
            return 0;
        else if (k < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // sink side stalls
    initial
    begin
        int g;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            out_ready <= 1'b1;
            g = gap_len();
            while (!(out_valid && out_ready))
                @(posedge clk);
            if (g > 0)
            begin
                out_ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("watchdog expired, %0d words still expected", pending);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    task automatic send_word(input pix_in_t w);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        words_sent++;
    endtask

    function automatic pix_in_t make_word(input logic [1:0] s, t, input logic [10:0] a,
                                          input logic [7:0] b, c, al);
        pix_in_t w;
        w.source_model = s; w.target_model = t;
        w.first_in = a; w.second_in = b; w.third_in = c; w.alpha_in = al;
        return w;
    endfunction

    function automatic pix_in_t rand_word();
        pix_in_t w;
        w.source_model = $urandom_range(0, 9) == 0 ? MODEL_BAD : 2'($urandom_range(0, 2));
        w.target_model = $urandom_range(0, 9) == 0 ? MODEL_BAD : 2'($urandom_range(0, 2));
        case ($urandom_range(0, 5))
            0: w.first_in = 11'($urandom);
            1: w.first_in = 11'($urandom_range(0, 255));
            default: w.first_in = 11'($urandom_range(0, 1535));
        endcase
        w.second_in = $urandom_range(0, 7) == 0 ? 8'(w.first_in) : 8'($urandom);
        w.third_in  = $urandom_range(0, 7) == 0 ? w.second_in : 8'($urandom);
        w.alpha_in  = 8'($urandom);
        return w;
    endfunction

    initial
    begin
        int n;
        in_valid    = 1'b0;
        in_data     = '0;
        words_sent  = 0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: all model pairs, extremes, achromatic, hue wrap, red clamp
        for (int s = 0; s < 4; s++)
            for (int t = 0; t < 4; t++)
                send_word(make_word(2'(s), 2'(t), 11'd200, 8'd90, 8'd30, 8'(s * 4 + t)));
        send_word(make_word(MODEL_RGB, MODEL_HSV, 11'd0, 8'd0, 8'd0, 8'h00));
        send_word(make_word(MODEL_RGB, MODEL_HSL, 11'd255, 8'd255, 8'd255, 8'hFF));
        send_word(make_word(MODEL_RGB, MODEL_HSV, 11'd2047, 8'd255, 8'd255, 8'h55));
        send_word(make_word(MODEL_RGB, MODEL_RGB, 11'd1000, 8'd1, 8'd2, 8'hAA));
        send_word(make_word(MODEL_HSL, MODEL_RGB, 11'd2047, 8'd255, 8'd128, 8'h12));
        send_word(make_word(MODEL_HSV, MODEL_HSV, 11'd1600, 8'd255, 8'd255, 8'h34));
        send_word(make_word(MODEL_HSL, MODEL_HSV, 11'd700, 8'd0, 8'd77, 8'h56));
        send_word(make_word(MODEL_HSV, MODEL_HSL, 11'd1535, 8'd255, 8'd0, 8'h78));
        send_word(make_word(MODEL_RGB, MODEL_HSL, 11'd100, 8'd100, 8'd40, 8'h9A));

        // random
        for (n = 0; n < 400; n++)
            send_word(rand_word());
        in_valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("sent %0d color words over all model pairs, checked %0d results",
                 words_sent, words_checked);
        if (fail_count == 0 && pending == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+design
design/rhhc_pkg.sv
design/rhhc_div.sv
design/rgb_hsl_hsv_converter.sv
dv/color_convert_checker.sv
dv/tb_top.sv
